### hw/rtl/odpm_pkg.sv
// Package for the offline device priority monitor.
// Shared constants, codes and handshake structs; no dependencies.
`timescale 1ns / 1ps

package odpm_pkg;

  localparam int NUM_DEVICES = 6;
  localparam int IDX_W       = 3;
  localparam int CNT_W       = 3;
  localparam int PRI_W       = 3;
  localparam int TIME_W      = 32;
  localparam int TMO_W       = 16;
  localparam int PTAB_W      = PRI_W * NUM_DEVICES;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 18;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 16;

  localparam logic [IDX_W-1:0] SEL_NONE = IDX_W'(NUM_DEVICES);

  localparam logic [TMO_W-1:0]       RST_TIMEOUT  = TMO_W'(200);
  localparam logic [NUM_DEVICES-1:0] RST_ENABLE   = {NUM_DEVICES{1'b1}};
  localparam logic [PTAB_W-1:0]      RST_PRIORITY = PTAB_W'(42798);

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY = 2'd2;

  localparam logic CMD_HEARTBEAT = 1'b0;
  localparam logic CMD_SCAN      = 1'b1;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] now;
  } scan_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } scan_sts_t;

endpackage

### hw/rtl/offline_device_priority_monitor_top.sv
// Offline device priority monitor, top level: stream ports, config registers,
// last-seen store, control and result register. Depends on odpm_pkg, odpm_scan.
// Heartbeat: ST_DONE registers the result once the output is free. Scan: walks the
// six devices one per cycle through one subtract/compare unit in ST_SCAN, then ST_DONE
// registers the result. Requests are taken only in ST_IDLE, one at a time.
// Reset (rst_n, synchronous, active low): times zero, nothing offline, no selection.
`timescale 1ns / 1ps

module offline_device_priority_monitor_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [odpm_pkg::IN_DATA_W-1:0]      in_tdata,   // device_id[2:0], now_ms[34:3]
  input  logic [0:0]                          in_tuser,   // cmd[0]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // offline_mask[5:0], offline_count[8:6], selected_id[11:9], any_offline[12]
  output logic [odpm_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [odpm_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [odpm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import odpm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [TMO_W-1:0]       timeout_r;
  logic [NUM_DEVICES-1:0] enable_r;
  logic [PTAB_W-1:0]      prio_r;
  logic [TIME_W-1:0]      seen_r [NUM_DEVICES];
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;

  logic                   in_fire;
  logic                   in_cmd;
  logic [IDX_W-1:0]       in_dev;
  logic [TIME_W-1:0]      in_now;
  logic                   hb_wr;
  scan_req_t              scan_req;
  scan_sts_t              scan_sts;
  logic [IDX_W-1:0]       rd_idx;
  logic [NUM_DEVICES-1:0] flags;
  logic [CNT_W-1:0]       total;
  logic [IDX_W-1:0]       sel;
  logic                   out_free;

  assign in_cmd   = in_tuser[0];
  assign in_dev   = in_tdata[IDX_W-1:0];
  assign in_now   = in_tdata[IDX_W +: TIME_W];
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire  = in_tvalid && in_tready;
  assign hb_wr    = in_fire && (in_cmd == CMD_HEARTBEAT)
                    && (32'(in_dev) < NUM_DEVICES) && enable_r[in_dev];
  assign out_free = !out_valid_r || out_tready;

  assign scan_req.start = in_fire && (in_cmd == CMD_SCAN);
  assign scan_req.now   = in_now;

  odpm_scan u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (scan_req),
    .timeout        (timeout_r),
    .enable_mask    (enable_r),
    .priority_table (prio_r),
    .rd_data        (seen_r[rd_idx]),
    .rd_idx         (rd_idx),
    .sts            (scan_sts),
    .flags          (flags),
    .total          (total),
    .sel            (sel)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_cmd == CMD_SCAN) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_sts.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_DATA_W'({sel != SEL_NONE, sel, total, flags});
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      timeout_r   <= RST_TIMEOUT;
      enable_r    <= RST_ENABLE;
      prio_r      <= RST_PRIORITY;
      for (int i = 0; i < NUM_DEVICES; i++) begin
        seen_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_TIMEOUT:  timeout_r <= cfg_wdata[TMO_W-1:0];
          CFG_ENABLE:   enable_r  <= cfg_wdata[NUM_DEVICES-1:0];
          CFG_PRIORITY: prio_r    <= cfg_wdata[PTAB_W-1:0];
          default: ;
        endcase
      end
      if (hb_wr) begin
        seen_r[in_dev] <= in_now;
      end
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_sts.done |-> (state_r == ST_SCAN))
    else $error("scan finished outside scan state");
  a_scan_starts: assert property (@(posedge clk) disable iff (!rst_n)
    scan_req.start |=> scan_sts.busy)
    else $error("scan request did not start the walk");
  a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[8:6] == CNT_W'($countones(out_data_r[5:0]))))
    else $error("result count disagrees with mask");

endmodule

### hw/rtl/odpm_gap_cmp.sv
// Shared gap unit: wrapping subtract of last-seen time and timeout compare.
// Depends on odpm_pkg.
`timescale 1ns / 1ps

module odpm_gap_cmp (
  input  logic [odpm_pkg::TIME_W-1:0] now,
  input  logic [odpm_pkg::TIME_W-1:0] seen,
  input  logic [odpm_pkg::TMO_W-1:0]  timeout,
  input  logic                        enabled,
  output logic                        offline
);
  import odpm_pkg::*;

  logic [TIME_W-1:0] gap;

  assign gap     = now - seen;
  assign offline = enabled && (gap > TIME_W'(timeout));

endmodule

### hw/rtl/odpm_scan.sv
// Scan sequencer: walks the devices one per cycle through the gap unit,
// keeps offline flags, count and selection. Depends on odpm_pkg, odpm_gap_cmp.
`timescale 1ns / 1ps

module odpm_scan (
  input  logic                             clk,
  input  logic                             rst_n,
  input  odpm_pkg::scan_req_t              req,
  input  logic [odpm_pkg::TMO_W-1:0]       timeout,
  input  logic [odpm_pkg::NUM_DEVICES-1:0] enable_mask,
  input  logic [odpm_pkg::PTAB_W-1:0]      priority_table,
  input  logic [odpm_pkg::TIME_W-1:0]      rd_data,
  output logic [odpm_pkg::IDX_W-1:0]       rd_idx,
  output odpm_pkg::scan_sts_t              sts,
  output logic [odpm_pkg::NUM_DEVICES-1:0] flags,
  output logic [odpm_pkg::CNT_W-1:0]       total,
  output logic [odpm_pkg::IDX_W-1:0]       sel
);
  import odpm_pkg::*;

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [TIME_W-1:0]      now_r, now_nxt;
  logic [NUM_DEVICES-1:0] facc_r, facc_nxt;
  logic [CNT_W-1:0]       cacc_r, cacc_nxt;
  logic [PRI_W-1:0]       best_r, best_nxt;
  logic [IDX_W-1:0]       sacc_r, sacc_nxt;
  logic [NUM_DEVICES-1:0] flags_r, flags_nxt;
  logic [CNT_W-1:0]       total_r, total_nxt;
  logic [IDX_W-1:0]       sel_r, sel_nxt;
  logic                   off;
  logic [PRI_W-1:0]       pri;
  logic                   last;

  odpm_gap_cmp u_gap (
    .now     (now_r),
    .seen    (rd_data),
    .timeout (timeout),
    .enabled (enable_mask[idx_r]),
    .offline (off)
  );

  assign pri  = priority_table[idx_r*PRI_W +: PRI_W];
  assign last = (idx_r == IDX_W'(NUM_DEVICES - 1));

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    idx_nxt   = idx_r;
    now_nxt   = now_r;
    facc_nxt  = facc_r;
    cacc_nxt  = cacc_r;
    best_nxt  = best_r;
    sacc_nxt  = sacc_r;
    flags_nxt = flags_r;
    total_nxt = total_r;
    sel_nxt   = sel_r;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      now_nxt  = req.now;
      facc_nxt = '0;
      cacc_nxt = '0;
      best_nxt = '0;
      sacc_nxt = sel_r;
    end else if (busy_r) begin
      facc_nxt = facc_r | (NUM_DEVICES'(off) << idx_r);
      cacc_nxt = cacc_r + CNT_W'(off);
      if (off && (pri > best_r)) begin
        best_nxt = pri;
        sacc_nxt = idx_r;
      end
      idx_nxt = idx_r + 1'b1;
      if (last) begin
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
        flags_nxt = facc_nxt;
        total_nxt = cacc_nxt;
        sel_nxt   = (cacc_nxt == '0) ? SEL_NONE : sacc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      idx_r   <= '0;
      flags_r <= '0;
      total_r <= '0;
      sel_r   <= SEL_NONE;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      idx_r   <= idx_nxt;
      flags_r <= flags_nxt;
      total_r <= total_nxt;
      sel_r   <= sel_nxt;
    end
    now_r  <= now_nxt;
    facc_r <= facc_nxt;
    cacc_r <= cacc_nxt;
    best_r <= best_nxt;
    sacc_r <= sacc_nxt;
  end

  assign rd_idx    = idx_r;
  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign flags     = flags_r;
  assign total     = total_r;
  assign sel       = sel_r;

  a_cnt_flags: assert property (@(posedge clk) disable iff (!rst_n)
    total_r == CNT_W'($countones(flags_r)))
    else $error("offline count does not match flags");
  a_zero_none: assert property (@(posedge clk) disable iff (!rst_n)
    (total_r == '0) |-> (sel_r == SEL_NONE))
    else $error("selection kept with nothing offline");
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("scan done without a walk");

endmodule

### tb/sv/odpm_status_checker.sv
// Status checker for the offline device priority monitor: watches the request,
// result and config ports, predicts each result and compares. Depends on odpm_pkg.
`timescale 1ns / 1ps

module odpm_status_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [odpm_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [0:0]                      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [odpm_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [odpm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [odpm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned                     pending,
  output int unsigned                     errors
);
  import odpm_pkg::*;

  typedef struct packed {
    logic [NUM_DEVICES-1:0] mask;
    logic [CNT_W-1:0]       count;
    logic [IDX_W-1:0]       sel;
    logic                   any_off;
  } dev_status_t;

  logic [TIME_W-1:0]      seen_ms [NUM_DEVICES];
  logic [NUM_DEVICES-1:0] off_mask;
  logic [CNT_W-1:0]       off_cnt;
  logic [IDX_W-1:0]       sel_dev;
  logic [TMO_W-1:0]       tmo_reg;
  logic [NUM_DEVICES-1:0] en_reg;
  logic [PTAB_W-1:0]      pri_reg;

  dev_status_t status_q[$];
  int unsigned err_cnt = 0;

  // Applies one request to the monitor state and returns the status after it.
  function automatic dev_status_t next_status(input logic cmd, input logic [IDX_W-1:0] dev,
                                              input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0]      gap;
    logic [PRI_W-1:0]       best;
    logic [NUM_DEVICES-1:0] mask;
    logic [CNT_W-1:0]       cnt;
    dev_status_t            st;
    if (cmd == CMD_HEARTBEAT) begin
      if (dev < NUM_DEVICES && en_reg[dev])
        seen_ms[dev] = now;
    end else begin
      best = '0;
      mask = '0;
      cnt  = '0;
      for (int i = 0; i < NUM_DEVICES; i++) begin
        gap = now - seen_ms[i];
        if (en_reg[i] && gap > TIME_W'(tmo_reg)) begin
          mask[i] = 1'b1;
          cnt++;
          if (pri_reg[PRI_W*i +: PRI_W] > best) begin
            best    = pri_reg[PRI_W*i +: PRI_W];
            sel_dev = IDX_W'(i);
          end
        end
      end
      off_mask = mask;
      off_cnt  = cnt;
      if (cnt == 0)
        sel_dev = SEL_NONE;
    end
    st.mask    = off_mask;
    st.count   = off_cnt;
    st.sel     = sel_dev;
    st.any_off = (sel_dev < NUM_DEVICES);
    return st;
  endfunction

  task automatic cmp_field(input string fname, input int unsigned exp_v,
                           input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", fname, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    dev_status_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_DEVICES; i++)
        seen_ms[i] = '0;
      off_mask = '0;
      off_cnt  = '0;
      sel_dev  = SEL_NONE;
      tmo_reg  = RST_TIMEOUT;
      en_reg   = RST_ENABLE;
      pri_reg  = RST_PRIORITY;
      status_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (status_q.size() == 0) begin
          $error("result with no request outstanding: %0h", out_tdata);
          err_cnt++;
        end else begin
          want = status_q.pop_front();
          cmp_field("offline_mask", 32'(want.mask), 32'(out_tdata[5:0]));
          cmp_field("offline_count", 32'(want.count), 32'(out_tdata[8:6]));
          cmp_field("selected_id", 32'(want.sel), 32'(out_tdata[11:9]));
          cmp_field("any_offline", 32'(want.any_off), 32'(out_tdata[12]));
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_TIMEOUT:  tmo_reg = cfg_wdata[TMO_W-1:0];
          CFG_ENABLE:   en_reg  = cfg_wdata[NUM_DEVICES-1:0];
          CFG_PRIORITY: pri_reg = cfg_wdata[PTAB_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        status_q.push_back(next_status(in_tuser[0], in_tdata[IDX_W-1:0],
                                       in_tdata[IDX_W +: TIME_W]));
    end
    pending <= status_q.size();
    errors  <= err_cnt;
  end

endmodule

### tb/sv/offline_device_priority_monitor_top_tb.sv
// Testbench top for the offline device priority monitor: clock, reset, request
// and config stimulus, result back-pressure, watchdog and verdict.
// Depends on odpm_pkg, offline_device_priority_monitor_top, odpm_status_checker.
`timescale 1ns / 1ps

module offline_device_priority_monitor_top_tb;
  import odpm_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [0:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  int unsigned pending;
  int unsigned errors;
  int unsigned quiet_cycles = 0;
  int unsigned hold_reqs    = 0;
  int unsigned holds_done   = 0;
  int unsigned hold_left    = 0;
  bit          calm         = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  offline_device_priority_monitor_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  odpm_status_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .errors     (errors)
  );

  // result side: random back-pressure, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (holds_done != hold_reqs) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 32);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[offline_device_priority_monitor_top] ERROR");
      $finish;
    end
  end

  task automatic send_req(input logic cmd, input logic [IDX_W-1:0] dev,
                          input logic [TIME_W-1:0] now);
    if (!calm && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({now, dev});
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering requests and wait for every result
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic load_config(input logic [TMO_W-1:0] tmo, input logic [NUM_DEVICES-1:0] en,
                             input logic [PTAB_W-1:0] pri);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_TIMEOUT;
    cfg_wdata <= CFG_DATA_W'(tmo);
    @(posedge clk);
    cfg_idx   <= CFG_ENABLE;
    cfg_wdata <= CFG_DATA_W'(en);
    @(posedge clk);
    cfg_idx   <= CFG_PRIORITY;
    cfg_wdata <= CFG_DATA_W'(pri);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // heartbeats and scans on a running clock, with some raw noise mixed in
  task automatic run_phase(input int unsigned n_items, input logic [TIME_W-1:0] t0,
                           input int unsigned step_max);
    logic [TIME_W-1:0] t;
    int unsigned       roll;
    t = t0;
    repeat (n_items) begin
      roll = $urandom_range(99);
      if (roll < 12) begin
        send_req(1'($urandom_range(1)), IDX_W'($urandom_range(7)), $urandom);
      end else begin
        t = t + $urandom_range(0, step_max);
        if (roll < 35)
          send_req(CMD_SCAN, IDX_W'($urandom_range(7)), t);
        else if (roll < 39)
          send_req(CMD_HEARTBEAT, IDX_W'($urandom_range(NUM_DEVICES, 7)), t);
        else
          send_req(CMD_HEARTBEAT, IDX_W'($urandom_range(NUM_DEVICES - 1)), t);
      end
    end
  endtask

  initial begin : stimulus
    logic [TMO_W-1:0]       tmo;
    logic [NUM_DEVICES-1:0] en;
    logic [PTAB_W-1:0]      pri;
    logic [TIME_W-1:0]      t0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset config: timeout 200, all enabled, priorities 6..1
    send_req(CMD_SCAN, 0, 0);
    send_req(CMD_SCAN, 0, 200);                       // gap equal to timeout
    send_req(CMD_SCAN, 7, 201);                       // all offline, device 0 wins
    send_req(CMD_HEARTBEAT, 0, 201);
    send_req(CMD_SCAN, 0, 300);
    send_req(CMD_HEARTBEAT, 6, 32'hFFFF_FFFF);        // out of range ids
    send_req(CMD_HEARTBEAT, 7, 0);
    send_req(CMD_HEARTBEAT, 5, 32'hFFFF_FFFF);
    send_req(CMD_SCAN, 0, 32'h0000_00C7);             // time wraps
    settle();

    load_config('0, '0, RST_PRIORITY);                // everything disabled
    send_req(CMD_HEARTBEAT, 2, 500);
    send_req(CMD_SCAN, 0, 600);
    settle();

    load_config('1, '1, '1);                          // max timeout, all priorities tie
    send_req(CMD_SCAN, 0, 32'h8000_0000);
    send_req(CMD_HEARTBEAT, 0, 32'h8000_0000);
    send_req(CMD_SCAN, 0, 32'h8000_FFFF);
    settle();

    load_config('0, '1, '0);                          // zero timeout, zero priorities
    send_req(CMD_SCAN, 0, 32'h8001_0000);             // stale selection kept
    for (int d = 0; d < NUM_DEVICES; d++)
      send_req(CMD_HEARTBEAT, IDX_W'(d), 32'h9000_0000);
    send_req(CMD_SCAN, 0, 32'h9000_0000);
    send_req(CMD_SCAN, 0, 32'h9000_0001);             // offline but none selectable
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       tmo = '0;
        1:       tmo = '1;
        2:       tmo = RST_TIMEOUT;
        default: tmo = $urandom_range(1) ? TMO_W'($urandom_range(0, 500))
                                         : TMO_W'($urandom_range(0, 65535));
      endcase
      en  = (p % 3 == 0) ? '1 : NUM_DEVICES'($urandom_range(0, 63));
      pri = (p == 1) ? '0 : (p == 2) ? '1 : PTAB_W'($urandom_range(0, 262143));
      if (p == 4)
        for (int d = 0; d < NUM_DEVICES; d++)
          if ($urandom_range(1))
            pri[PRI_W*d +: PRI_W] = '0;
      t0 = (p == 3) ? 32'hFFFF_FF00 : $urandom;
      load_config(tmo, en, pri);
      calm = (p == 5 || p == 6);
      if (p == 6)
        hold_reqs <= hold_reqs + 1;
      run_phase(240, t0, 32'(tmo) / 4 + 1);
      settle();
    end
    calm = 1'b0;

    if (errors == 0)
      $display("[offline_device_priority_monitor_top] OK");
    else
      $display("[offline_device_priority_monitor_top] ERROR");
    $finish;
  end

endmodule
